// ===== hw/rtl/rvpc_pkg.sv =====
// rvpc_pkg: types, character codes and helper functions for the release
// version parse/compare block; used by every rtl file of the block but rvpc_if
package rvpc_pkg;

   localparam int unsigned NUM_WIDTH = 20;
   localparam int unsigned PROD_WIDTH = 24;
   localparam int unsigned TAG_LEN = 6;
   localparam int unsigned TAG_IDX_WIDTH = 3;

   localparam logic [7:0] CHAR_ZERO = 8'h30;
   localparam logic [7:0] CHAR_NINE = 8'h39;
   localparam logic [7:0] CHAR_DOT = 8'h2e;
   localparam logic [7:0] CHAR_DASH = 8'h2d;
   localparam logic [7:0] CHAR_LOWER_R = 8'h72;
   localparam logic [7:0] CHAR_LOWER_C = 8'h63;
   localparam logic [7:0] CHAR_LOWER_V = 8'h76;
   localparam logic [7:0] CHAR_UPPER_V = 8'h56;

   localparam logic KIND_LATEST = 1'b0;
   localparam logic KIND_CURRENT = 1'b1;

   typedef enum logic [2:0] {
      PH_MAJOR,
      PH_MINOR,
      PH_PATCH,
      PH_MARKER,
      PH_BUILD,
      PH_REST
   } phase_type;

   typedef enum logic [1:0] {
      PFX_OPEN,
      PFX_R,
      PFX_DONE
   } prefix_type;

   typedef enum logic [1:0] {
      DASH_IDLE,
      DASH_SEEN,
      DASH_R
   } dash_type;

   typedef struct packed {
      prefix_type prefix;
      dash_type   dash;
      logic       cand;
   } rest_track_type;

   typedef struct packed {
      logic [7:0] character;
      logic       which_string;
      logic       has_char;
      logic       last;
   } item_type;

   typedef struct packed {
      logic [NUM_WIDTH-1:0] major;
      logic [NUM_WIDTH-1:0] minor;
      logic [NUM_WIDTH-1:0] patch;
      logic [NUM_WIDTH-1:0] build;
   } tuple_type;

   typedef struct packed {
      logic      string_kind;
      logic      parsed_ok;
      tuple_type nums;
      logic      release_candidate;
      logic      newer;
   } result_type;

   function automatic logic [7:0] tag_char(input logic [TAG_IDX_WIDTH-1:0] idx);
      logic [7:0] ch;
      unique case (idx)
         3'd0: ch = 8'h2d;
         3'd1: ch = 8'h6c;
         3'd2: ch = 8'h65;
         3'd3: ch = 8'h78;
         3'd4: ch = 8'h69;
         3'd5: ch = 8'h2e;
         default: ch = 8'h00;
      endcase
      return ch;
   endfunction

   // candidate trackers over the trailing text
   function automatic rest_track_type track_rest(input logic [7:0] c,
                                                 input rest_track_type t);
      rest_track_type r;
      r = t;
      priority case (t.prefix)
         PFX_OPEN: r.prefix = (c == CHAR_LOWER_R) ? PFX_R : PFX_DONE;
         PFX_R: begin
            if (c == CHAR_LOWER_C) r.cand = 1'b1;
            r.prefix = PFX_DONE;
         end
         default: r.prefix = t.prefix;
      endcase
      if (c == CHAR_DASH) begin
         r.dash = DASH_SEEN;
      end else if (t.dash == DASH_SEEN && c == CHAR_LOWER_R) begin
         r.dash = DASH_R;
      end else begin
         if (t.dash == DASH_R && c == CHAR_LOWER_C) r.cand = 1'b1;
         r.dash = DASH_IDLE;
      end
      return r;
   endfunction

endpackage

// ===== hw/rtl/rvpc_if.sv =====
// rvpc_req_if / rvpc_rsp_if: valid/ready channels of the version block
// depends on nothing; field widths follow the block's item layout
interface rvpc_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] character;
   logic       which_string;
   logic       has_char;
   logic       last;

   modport source(output valid, character, which_string, has_char, last, input ready);
   modport sink(input valid, character, which_string, has_char, last, output ready);
endinterface

interface rvpc_rsp_if;
   logic        valid;
   logic        ready;
   logic        string_kind;
   logic        parsed_ok;
   logic [19:0] major_number;
   logic [19:0] minor_number;
   logic [19:0] patch_number;
   logic [19:0] build_number;
   logic        release_candidate;
   logic        newer;

   modport source(output valid, string_kind, parsed_ok, major_number, minor_number,
                  patch_number, build_number, release_candidate, newer, input ready);
   modport sink(input valid, string_kind, parsed_ok, major_number, minor_number,
                patch_number, build_number, release_candidate, newer, output ready);
endinterface

// ===== hw/rtl/rvpc_in_stage.sv =====
// rvpc_in_stage: input register for one request beat
// depends on rvpc_pkg and rvpc_req_if
module rvpc_in_stage (
   input  logic              clock,
   input  logic              reset,
   rvpc_req_if.sink          req,
   input  logic              fire,
   output logic              item_valid,
   output rvpc_pkg::item_type item
);
   import rvpc_pkg::*;

   logic     valid_ff;
   logic     valid_in;
   item_type item_ff;

   assign req.ready = !valid_ff || fire;
   assign valid_in = req.ready ? req.valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req.valid && req.ready) begin
         item_ff <= '{character: req.character, which_string: req.which_string,
                      has_char: req.has_char, last: req.last};
      end
   end

   assign item_valid = valid_ff;
   assign item = item_ff;
endmodule

// ===== hw/rtl/rvpc_compare.sv =====
// rvpc_compare: decides whether the saved latest version replaces the current one
// depends on rvpc_pkg
module rvpc_compare (
   input  rvpc_pkg::tuple_type saved,
   input  logic                saved_eligible,
   input  rvpc_pkg::tuple_type cur,
   input  logic                cur_ok,
   input  logic                cur_rc,
   output logic                newer
);
   import rvpc_pkg::*;

   always_comb begin
      if (!saved_eligible) begin
         newer = 1'b0;
      end else if (!cur_ok) begin
         newer = 1'b1;
      end else if (saved.major != cur.major) begin
         newer = saved.major > cur.major;
      end else if (saved.minor != cur.minor) begin
         newer = saved.minor > cur.minor;
      end else if (saved.patch != cur.patch) begin
         newer = saved.patch > cur.patch;
      end else if (saved.build != cur.build) begin
         newer = saved.build > cur.build;
      end else begin
         newer = cur_rc;
      end
   end
endmodule

// ===== hw/rtl/rvpc_parser.sv =====
// rvpc_parser: per-character parse state, end-of-string result and saved latest
// depends on rvpc_pkg and rvpc_compare
module rvpc_parser #(
   parameter int unsigned COMPONENT_LIMIT = 1000000
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 fire,
   input  rvpc_pkg::item_type   item,
   output rvpc_pkg::result_type result
);
   import rvpc_pkg::*;

   localparam logic [PROD_WIDTH-1:0] LIMIT = PROD_WIDTH'(COMPONENT_LIMIT);

   phase_type                phase_ff, phase_in;
   logic                     first_ff, first_in;
   logic [NUM_WIDTH-1:0]     accum_ff, accum_in;
   logic                     seen_ff, seen_in;
   logic                     failed_ff, failed_in;
   tuple_type                work_ff, work_in;
   logic [TAG_IDX_WIDTH-1:0] tag_idx_ff, tag_idx_in;
   rest_track_type           track_ff, track_in;
   tuple_type                saved_ff, saved_in;
   logic                     eligible_ff, eligible_in;

   logic [7:0]           c;
   logic                 is_digit;
   logic [PROD_WIDTH-1:0] prod;
   logic                 over;
   phase_type            ph;
   logic [TAG_IDX_WIDTH-1:0] mi;
   logic                 ok;
   tuple_type            cur;
   logic                 cur_rc;
   logic                 newer;

   assign c = item.character;
   assign is_digit = (c >= CHAR_ZERO) && (c <= CHAR_NINE);
   assign prod = {1'b0, accum_ff, 3'b000} + {3'b000, accum_ff, 1'b0}
               + {{(PROD_WIDTH-4){1'b0}}, c[3:0]};
   assign over = prod > LIMIT;

   always_comb begin
      phase_in = phase_ff;
      first_in = first_ff;
      accum_in = accum_ff;
      seen_in = seen_ff;
      failed_in = failed_ff;
      work_in = work_ff;
      tag_idx_in = tag_idx_ff;
      track_in = track_ff;
      saved_in = saved_ff;
      eligible_in = eligible_ff;
      ph = phase_ff;
      mi = tag_idx_ff;

      if (fire && item.has_char && !failed_ff) begin
         first_in = 1'b0;
         if (!(first_ff && (c == CHAR_LOWER_V || c == CHAR_UPPER_V))) begin
            if (ph == PH_PATCH && !is_digit && seen_ff) begin
               work_in.patch = accum_ff;
               ph = PH_MARKER;
               mi = '0;
            end
            unique case (ph)
               PH_MAJOR, PH_MINOR: begin
                  if (is_digit) begin
                     if (over) failed_in = 1'b1;
                     else begin
                        accum_in = prod[NUM_WIDTH-1:0];
                        seen_in = 1'b1;
                     end
                  end else if (!seen_ff || c != CHAR_DOT) begin
                     failed_in = 1'b1;
                  end else begin
                     if (ph == PH_MAJOR) begin
                        work_in.major = accum_ff;
                        phase_in = PH_MINOR;
                     end else begin
                        work_in.minor = accum_ff;
                        phase_in = PH_PATCH;
                     end
                     accum_in = '0;
                     seen_in = 1'b0;
                  end
               end
               PH_PATCH: begin
                  if (is_digit) begin
                     if (over) failed_in = 1'b1;
                     else begin
                        accum_in = prod[NUM_WIDTH-1:0];
                        seen_in = 1'b1;
                     end
                  end else begin
                     failed_in = 1'b1;
                  end
               end
               PH_MARKER: begin
                  track_in = track_rest(c, track_ff);
                  if (mi < TAG_IDX_WIDTH'(TAG_LEN) && c == tag_char(mi)) begin
                     tag_idx_in = mi + TAG_IDX_WIDTH'(1);
                     phase_in = PH_MARKER;
                     if (mi == TAG_IDX_WIDTH'(TAG_LEN - 1)) begin
                        phase_in = PH_BUILD;
                        track_in.prefix = PFX_OPEN;
                        track_in.dash = DASH_IDLE;
                        accum_in = '0;
                        seen_in = 1'b0;
                     end
                  end else begin
                     tag_idx_in = mi;
                     phase_in = PH_REST;
                  end
               end
               PH_BUILD: begin
                  if (is_digit) begin
                     if (over) failed_in = 1'b1;
                     else begin
                        accum_in = prod[NUM_WIDTH-1:0];
                        seen_in = 1'b1;
                     end
                  end else begin
                     work_in.build = accum_ff;
                     phase_in = PH_REST;
                     track_in = track_rest(c, track_ff);
                  end
               end
               PH_REST: track_in = track_rest(c, track_ff);
               default: phase_in = phase_ff;
            endcase
         end
      end

      // end of string: close the open field and build the result beat
      cur = work_in;
      if (phase_in == PH_PATCH) cur.patch = accum_in;
      if (phase_in == PH_BUILD) cur.build = accum_in;
      ok = !failed_in && ((phase_in == PH_PATCH && seen_in) || phase_in == PH_MARKER
                          || phase_in == PH_BUILD || phase_in == PH_REST);
      if (!ok) cur = '0;
      cur_rc = ok && track_in.cand;

      if (fire && item.last) begin
         if (item.which_string == KIND_LATEST) begin
            saved_in = cur;
            eligible_in = ok && (cur.build != '0) && !cur_rc;
         end
         phase_in = PH_MAJOR;
         first_in = 1'b1;
         accum_in = '0;
         seen_in = 1'b0;
         failed_in = 1'b0;
         work_in = '0;
         tag_idx_in = '0;
         track_in = '{prefix: PFX_OPEN, dash: DASH_IDLE, cand: 1'b0};
      end
   end

   rvpc_compare u_compare (
      .saved          (saved_ff),
      .saved_eligible (eligible_ff),
      .cur            (cur),
      .cur_ok         (ok),
      .cur_rc         (cur_rc),
      .newer          (newer)
   );

   assign result = '{string_kind: item.which_string, parsed_ok: ok, nums: cur,
                     release_candidate: cur_rc,
                     newer: (item.which_string == KIND_CURRENT) && newer};

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_MAJOR;
         first_ff <= 1'b1;
         accum_ff <= '0;
         seen_ff <= 1'b0;
         failed_ff <= 1'b0;
         work_ff <= '0;
         tag_idx_ff <= '0;
         track_ff <= '{prefix: PFX_OPEN, dash: DASH_IDLE, cand: 1'b0};
         eligible_ff <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         first_ff <= first_in;
         accum_ff <= accum_in;
         seen_ff <= seen_in;
         failed_ff <= failed_in;
         work_ff <= work_in;
         tag_idx_ff <= tag_idx_in;
         track_ff <= track_in;
         eligible_ff <= eligible_in;
      end
   end

   always_ff @(posedge clock) begin
      saved_ff <= saved_in;
   end
endmodule

// ===== hw/rtl/release_version_parse_compare_core.sv =====
// release_version_parse_compare_core: parses a latest and a current version
// string one byte per beat and reports parse results and the newer flag
// depends on rvpc_pkg, rvpc_if, rvpc_in_stage and rvpc_parser
//
// usage
//   req_bus carries one byte per beat (character, which_string, has_char,
//   last); a latest string is sent first, then one or more current strings
//   rsp_bus carries one result beat for every request beat with last set;
//   newer is only ever set on results for a current string
//   throughput: one request beat per cycle while no final beat waits for
//   the result register; each character updates the parse state between
//   the input register and the result register
//   each result is registered from the final byte in the input register
//   reset: clears the parse state and forgets the saved latest
//   stall: the result register holds while rsp_bus.ready is low; beats that
//   end no string keep flowing, and a final beat waits in the input
//   register until the result register frees up
module release_version_parse_compare_core #(
   parameter int unsigned COMPONENT_LIMIT = 1000000
) (
   input  logic        clock,
   input  logic        reset,
   rvpc_req_if.sink    req_bus,
   rvpc_rsp_if.source  rsp_bus
);
   import rvpc_pkg::*;

   logic       item_valid;
   item_type   item;
   logic       out_free;
   logic       fire;
   result_type result;

   logic       rsp_valid_ff, rsp_valid_in;
   result_type rsp_data_ff;

   assign out_free = !rsp_valid_ff || rsp_bus.ready;
   assign fire = item_valid && (!item.last || out_free);

   rvpc_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .req        (req_bus),
      .fire       (fire),
      .item_valid (item_valid),
      .item       (item)
   );

   rvpc_parser #(
      .COMPONENT_LIMIT (COMPONENT_LIMIT)
   ) u_parser (
      .clock  (clock),
      .reset  (reset),
      .fire   (fire),
      .item   (item),
      .result (result)
   );

   assign rsp_valid_in = out_free ? (fire && item.last) : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire && item.last) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp_bus.valid = rsp_valid_ff;
   assign rsp_bus.string_kind = rsp_data_ff.string_kind;
   assign rsp_bus.parsed_ok = rsp_data_ff.parsed_ok;
   assign rsp_bus.major_number = rsp_data_ff.nums.major;
   assign rsp_bus.minor_number = rsp_data_ff.nums.minor;
   assign rsp_bus.patch_number = rsp_data_ff.nums.patch;
   assign rsp_bus.build_number = rsp_data_ff.nums.build;
   assign rsp_bus.release_candidate = rsp_data_ff.release_candidate;
   assign rsp_bus.newer = rsp_data_ff.newer;

   a_rsp_from_item: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(item_valid && item.last))
      else $error("result beat without a final request beat");

   a_newer_on_current: assert property (@(posedge clock) disable iff (reset)
      (rsp_bus.valid && rsp_bus.newer) |-> (rsp_bus.string_kind == KIND_CURRENT))
      else $error("newer set on a latest result");

   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_bus.valid && !rsp_bus.parsed_ok) |->
         (rsp_bus.major_number == '0 && rsp_bus.build_number == '0
          && !rsp_bus.release_candidate))
      else $error("failed parse carries nonzero fields");

   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !item_valid |-> req_bus.ready)
      else $error("input stage empty but not ready");
endmodule

// ===== verif/release_version_check.sv =====
// release_version_check: watches the request and result channels of the version
// parse/compare block, predicts each result and compares it field by field
// depends on rvpc_pkg and the rvpc_req_if / rvpc_rsp_if interfaces
`timescale 1ns / 100ps

module release_version_check #(
   parameter int unsigned COMPONENT_LIMIT = 1000000
) (
   input  logic        clock,
   input  logic        reset,
   rvpc_req_if         req_mon,
   rvpc_rsp_if         rsp_mon,
   output int unsigned error_count,
   output int unsigned results_outstanding
);
   import rvpc_pkg::*;

   localparam logic [7:0] BUILD_TAG [TAG_LEN] = '{8'h2d, 8'h6c, 8'h65, 8'h78, 8'h69, 8'h2e};

   phase_type   phase;
   logic        at_first;
   int unsigned accum;
   logic        have_digit;
   logic        failed;
   tuple_type   work;
   int unsigned tag_pos;
   prefix_type  pfx;
   dash_type    dash;
   logic        cand;
   tuple_type   saved;
   logic        saved_ok;

   result_type  expected_results[$];
   int unsigned mismatch_total = 0;

   assign error_count = mismatch_total;

   task automatic clear_string_state();
      phase = PH_MAJOR;
      at_first = 1'b1;
      accum = 0;
      have_digit = 1'b0;
      failed = 1'b0;
      work = '0;
      tag_pos = 0;
      pfx = PFX_OPEN;
      dash = DASH_IDLE;
      cand = 1'b0;
   endtask

   task automatic add_digit(input logic [7:0] c);
      int unsigned n;
      n = accum * 10 + int'(c) - int'(CHAR_ZERO);
      if (n > COMPONENT_LIMIT) begin
         failed = 1'b1;
      end else begin
         accum = n;
         have_digit = 1'b1;
      end
   endtask

   // candidate marks: rc opening the trailing text, or -rc anywhere in it
   task automatic scan_rest(input logic [7:0] c);
      case (pfx)
         PFX_OPEN: pfx = (c == CHAR_LOWER_R) ? PFX_R : PFX_DONE;
         PFX_R: begin
            if (c == CHAR_LOWER_C) cand = 1'b1;
            pfx = PFX_DONE;
         end
         default: ;
      endcase
      if (c == CHAR_DASH) begin
         dash = DASH_SEEN;
      end else if (dash == DASH_SEEN && c == CHAR_LOWER_R) begin
         dash = DASH_R;
      end else begin
         if (dash == DASH_R && c == CHAR_LOWER_C) cand = 1'b1;
         dash = DASH_IDLE;
      end
   endtask

   task automatic scan_tag(input logic [7:0] c);
      scan_rest(c);
      if (tag_pos < TAG_LEN && c == BUILD_TAG[tag_pos]) begin
         tag_pos++;
         if (tag_pos == TAG_LEN) begin
            phase = PH_BUILD;
            pfx = PFX_OPEN;
            dash = DASH_IDLE;
            accum = 0;
            have_digit = 1'b0;
         end
      end else begin
         phase = PH_REST;
      end
   endtask

   task automatic take_char(input logic [7:0] c);
      logic digit;
      digit = (c >= CHAR_ZERO && c <= CHAR_NINE);
      if (failed) return;
      if (at_first) begin
         at_first = 1'b0;
         if (c == CHAR_LOWER_V || c == CHAR_UPPER_V) return;
      end
      case (phase)
         PH_MAJOR, PH_MINOR: begin
            if (digit) begin
               add_digit(c);
            end else if (!have_digit || c != CHAR_DOT) begin
               failed = 1'b1;
            end else begin
               if (phase == PH_MAJOR) begin
                  work.major = accum[NUM_WIDTH-1:0];
                  phase = PH_MINOR;
               end else begin
                  work.minor = accum[NUM_WIDTH-1:0];
                  phase = PH_PATCH;
               end
               accum = 0;
               have_digit = 1'b0;
            end
         end
         PH_PATCH: begin
            if (digit) begin
               add_digit(c);
            end else if (!have_digit) begin
               failed = 1'b1;
            end else begin
               work.patch = accum[NUM_WIDTH-1:0];
               phase = PH_MARKER;
               tag_pos = 0;
               scan_tag(c);
            end
         end
         PH_MARKER: scan_tag(c);
         PH_BUILD: begin
            if (digit) begin
               add_digit(c);
            end else begin
               work.build = accum[NUM_WIDTH-1:0];
               phase = PH_REST;
               scan_rest(c);
            end
         end
         default: scan_rest(c);
      endcase
   endtask

   task automatic end_string(input logic kind, output result_type r);
      logic ok;
      if (phase == PH_PATCH) work.patch = accum[NUM_WIDTH-1:0];
      if (phase == PH_BUILD) work.build = accum[NUM_WIDTH-1:0];
      ok = !failed && ((phase == PH_PATCH && have_digit) || phase == PH_MARKER ||
                       phase == PH_BUILD || phase == PH_REST);
      r = '0;
      r.string_kind = kind;
      r.parsed_ok = ok;
      if (ok) begin
         r.nums = work;
         r.release_candidate = cand;
      end
      if (kind == KIND_LATEST) begin
         saved = r.nums;
         saved_ok = ok && r.nums.build != '0 && !r.release_candidate;
      end else if (saved_ok) begin
         // packed tuple compares major first, then minor, patch, build
         if (!ok) r.newer = 1'b1;
         else if (saved != r.nums) r.newer = (saved > r.nums);
         else r.newer = r.release_candidate;
      end
      clear_string_state();
   endtask

   task automatic check_field(input string field_name, input int unsigned want,
                              input int unsigned got);
      if (want != got) begin
         $error("%s mismatch: expected %0d, got %0d", field_name, want, got);
         mismatch_total++;
      end
   endtask

   always @(posedge clock) begin : watch_beats
      result_type want;
      if (reset) begin
         clear_string_state();
         saved = '0;
         saved_ok = 1'b0;
      end else begin
         if (req_mon.valid && req_mon.ready) begin
            if (req_mon.has_char) take_char(req_mon.character);
            if (req_mon.last) begin
               end_string(req_mon.which_string, want);
               expected_results.push_back(want);
            end
         end
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (expected_results.size() == 0) begin
               $error("result beat with no expected result waiting");
               mismatch_total++;
            end else begin
               want = expected_results.pop_front();
               check_field("string_kind", want.string_kind, rsp_mon.string_kind);
               check_field("parsed_ok", want.parsed_ok, rsp_mon.parsed_ok);
               check_field("major_number", want.nums.major, rsp_mon.major_number);
               check_field("minor_number", want.nums.minor, rsp_mon.minor_number);
               check_field("patch_number", want.nums.patch, rsp_mon.patch_number);
               check_field("build_number", want.nums.build, rsp_mon.build_number);
               check_field("release_candidate", want.release_candidate,
                           rsp_mon.release_candidate);
               check_field("newer", want.newer, rsp_mon.newer);
            end
         end
      end
      results_outstanding <= expected_results.size();
   end

endmodule

// ===== verif/release_version_parse_compare_core_tb.sv =====
// release_version_parse_compare_core_tb: drives version strings into the block
// with bursty input and a stalling receiver, and reports the verdict
// depends on rvpc_pkg, rvpc_if, the block's rtl and release_version_check
`timescale 1ns / 100ps

module release_version_parse_compare_core_tb;
   import rvpc_pkg::*;

   typedef logic [7:0] byte_queue_type[$];

   localparam int unsigned COMPONENT_LIMIT = 1000000;
   localparam int ITEM_TARGET = 1650;
   localparam int CYCLE_LIMIT = 500000;
   localparam int DRAIN_CYCLES = 10;
   localparam int HOLD_OFF_START = 200;
   localparam int HOLD_OFF_CYCLES = 500;

   logic           clock;
   logic           reset;
   int unsigned    error_count;
   int unsigned    results_outstanding;
   int             cycle_count = 0;
   int             burst_left = 0;
   int             sent_items = 0;
   int unsigned    latest_nums[4] = '{1, 0, 0, 1};
   byte_queue_type text_buf;

   rvpc_req_if req_bus ();
   rvpc_rsp_if rsp_bus ();

   release_version_parse_compare_core #(
      .COMPONENT_LIMIT(COMPONENT_LIMIT)
   ) u_top (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   release_version_check #(
      .COMPONENT_LIMIT(COMPONENT_LIMIT)
   ) u_check (
      .clock               (clock),
      .reset               (reset),
      .req_mon             (req_bus),
      .rsp_mon             (rsp_bus),
      .error_count         (error_count),
      .results_outstanding (results_outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // receiver: stall patterns that change every so often, one long hold-off
   initial begin
      int rx_cycle;
      int mode_left;
      int stall_pct;
      rx_cycle = 0;
      mode_left = 0;
      stall_pct = 0;
      rsp_bus.ready = 1'b0;
      forever begin
         @(posedge clock);
         rx_cycle++;
         if (rx_cycle == HOLD_OFF_START) begin
            rsp_bus.ready <= 1'b0;
            repeat (HOLD_OFF_CYCLES) @(posedge clock);
         end
         if (mode_left == 0) begin
            mode_left = $urandom_range(20, 200);
            case ($urandom_range(0, 4))
               0, 1: stall_pct = 0;
               2: stall_pct = 30;
               3: stall_pct = 60;
               default: stall_pct = 90;
            endcase
         end
         mode_left--;
         rsp_bus.ready <= ($urandom_range(0, 99) >= stall_pct);
      end
   end

   task automatic send_beat(input logic [7:0] ch, input logic ws, input logic hs,
                            input logic lst);
      int gap;
      if (burst_left == 0) begin
         req_bus.valid <= 1'b0;
         gap = $urandom_range(1, 8);
         repeat (gap) @(posedge clock);
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                  : $urandom_range(1, 6);
      end
      burst_left--;
      req_bus.valid <= 1'b1;
      req_bus.character <= ch;
      req_bus.which_string <= ws;
      req_bus.has_char <= hs;
      req_bus.last <= lst;
      do @(posedge clock); while (!req_bus.ready);
   endtask

   task automatic put_text(input string t);
      for (int i = 0; i < t.len(); i++) text_buf.push_back(t[i]);
   endtask

   task automatic put_tag(input int n);
      for (int i = 0; i < n; i++) text_buf.push_back(tag_char(3'(i)));
   endtask

   task automatic put_number(input int unsigned v);
      int zeros;
      zeros = ($urandom_range(0, 15) == 0) ? $urandom_range(1, 8) : 0;
      repeat (zeros) text_buf.push_back(CHAR_ZERO);
      put_text($sformatf("%0d", v));
   endtask

   function automatic int unsigned pick_number();
      case ($urandom_range(0, 9))
         0, 1, 2, 3, 4: return $urandom_range(0, 12);
         5, 6: return $urandom_range(0, 9999);
         7: return $urandom_range(COMPONENT_LIMIT - 2, COMPONENT_LIMIT + 2);
         8: return $urandom_range(0, 1048575);
         default: return $urandom_range(1000000, 99999999);
      endcase
   endfunction

   task automatic build_version(input logic is_current);
      int unsigned nums[4];
      int idx;
      int n;
      string junk;
      text_buf.delete();
      junk = "-rc.1a";
      if ($urandom_range(0, 15) == 0) begin
         n = $urandom_range(0, 8);
         repeat (n) text_buf.push_back(8'($urandom_range(0, 255)));
         return;
      end
      if (is_current && $urandom_range(0, 1) == 1) begin
         nums = latest_nums;
         if ($urandom_range(0, 1) == 1) begin
            idx = $urandom_range(0, 3);
            if ($urandom_range(0, 1) == 1) nums[idx]++;
            else if (nums[idx] != 0) nums[idx]--;
         end
      end else begin
         foreach (nums[i]) nums[i] = pick_number();
      end
      if (!is_current) latest_nums = nums;
      case ($urandom_range(0, 7))
         0: text_buf.push_back(CHAR_LOWER_V);
         1: text_buf.push_back(CHAR_UPPER_V);
         default: ;
      endcase
      put_number(nums[0]);
      text_buf.push_back(CHAR_DOT);
      put_number(nums[1]);
      text_buf.push_back(CHAR_DOT);
      put_number(nums[2]);
      if ($urandom_range(0, 3) != 0) begin
         put_tag(TAG_LEN);
         if ($urandom_range(0, 4) != 0) put_number(nums[3]);
      end
      case ($urandom_range(0, 9))
         0: put_text("rc1");
         1: put_text("-rc2");
         2: put_text("-beta");
         3: put_text("r");
         4: put_text("-r-rc");
         5: begin
            n = $urandom_range(1, 5);
            repeat (n) text_buf.push_back(junk[$urandom_range(0, junk.len() - 1)]);
         end
         6: put_tag($urandom_range(1, 5));
         7: put_text("rC");
         default: ;
      endcase
      // broken strings: a corrupted byte, a cut-off tail or a dropped byte
      if ($urandom_range(0, 9) == 0 && text_buf.size() > 0) begin
         case ($urandom_range(0, 2))
            0: text_buf[$urandom_range(0, text_buf.size() - 1)] = 8'($urandom_range(0, 255));
            1: begin
               n = $urandom_range(0, text_buf.size());
               while (text_buf.size() > n) void'(text_buf.pop_back());
            end
            default: text_buf.delete($urandom_range(0, text_buf.size() - 1));
         endcase
      end
   endtask

   task automatic send_text(input logic kind, input logic mix);
      logic ws;
      int n;
      n = text_buf.size();
      if (n == 0) begin
         send_beat(8'($urandom_range(0, 255)), kind, 1'b0, 1'b1);
         sent_items++;
      end else begin
         for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 24) == 0)
               send_beat(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b0, 1'b0);
            ws = (mix && i != n - 1) ? 1'($urandom_range(0, 1)) : kind;
            send_beat(text_buf[i], ws, 1'b1, i == n - 1);
            sent_items++;
         end
      end
   endtask

   initial begin
      int plan;
      int n_cur;
      reset = 1'b1;
      req_bus.valid = 1'b0;
      req_bus.character = '0;
      req_bus.which_string = 1'b0;
      req_bus.has_char = 1'b0;
      req_bus.last = 1'b0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // current with no latest yet, empty string
      send_beat(8'hff, KIND_CURRENT, 1'b0, 1'b1);
      sent_items++;
      // beat without a byte that ends nothing
      send_beat(8'h00, KIND_LATEST, 1'b0, 1'b0);
      text_buf.delete();
      put_text("v1.2.3");
      put_tag(TAG_LEN);
      put_text("7");
      send_text(KIND_LATEST, 1'b0);
      // equal tuples, current marked as candidate
      text_buf.delete();
      put_text("1.2.3");
      put_tag(TAG_LEN);
      put_text("7rc");
      send_text(KIND_CURRENT, 1'b0);
      // major above the limit
      text_buf.delete();
      put_text("V1000001");
      send_text(KIND_CURRENT, 1'b0);

      while (sent_items < ITEM_TARGET) begin
         plan = $urandom_range(0, 9);
         n_cur = 0;
         if (plan < 7) begin
            build_version(1'b0);
            send_text(KIND_LATEST, $urandom_range(0, 9) == 0);
            n_cur = $urandom_range(1, 3);
         end else if (plan < 9) begin
            n_cur = $urandom_range(1, 2);
         end else begin
            build_version(1'b0);
            send_text(KIND_LATEST, $urandom_range(0, 9) == 0);
         end
         repeat (n_cur) begin
            build_version(1'b1);
            send_text(KIND_CURRENT, $urandom_range(0, 9) == 0);
         end
      end

      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (results_outstanding != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
